// ===== rtl/midi_step_sequencer_unit_macros.svh =====
// Assertion macros shared by the step sequencer RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef MIDI_STEP_SEQUENCER_UNIT_MACROS_SVH
`define MIDI_STEP_SEQUENCER_UNIT_MACROS_SVH

// Condition that must hold at every clock edge.
`define MSS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define MSS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define MSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mss_pkg.sv =====
// Shared types, codes, constants and helper functions of the step sequencer.
// Used by every module of the block; depends on nothing.
package mss_pkg;

  localparam int NUM_STEPS_DEF = 16;
  localparam int QUEUE_DEPTH   = 4;

  localparam int REG_W       = 27;
  localparam int PHASE_W     = 28;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_DATA_W   = 24;
  localparam int IN_USER_W   = 3;
  localparam int OUT_DATA_W  = 32;
  localparam int OUT_USER_W  = 2;
  localparam int STEP_OUT_W  = 4;

  localparam logic [REG_W-1:0]   PERIOD_RST  = 27'd1536000;
  localparam logic [REG_W-1:0]   THRESH_RST  = 27'd768000;
  localparam logic [REG_W-1:0]   ONE_SAMPLE  = 27'd256;
  localparam logic [PHASE_W-1:0] PHASE_STEP  = 28'd256;

  localparam logic [6:0] NOTE_DEFAULT = 7'd60;
  localparam logic [7:0] OCTAVE       = 8'd12;
  localparam logic [7:0] NOTE_MAX     = 8'd127;
  localparam logic [6:0] SEQ_VELOCITY = 7'd100;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOTEOFF_THR = 2'd1;

  // Pattern step values.
  localparam logic [1:0] STEP_OFF  = 2'd0;
  localparam logic [1:0] STEP_ROOT = 2'd1;
  localparam logic [1:0] STEP_UP   = 2'd2;
  localparam logic [1:0] STEP_DOWN = 2'd3;

  typedef enum logic [2:0] {
    OP_TICK          = 3'd0,
    OP_NOTE_ON       = 3'd1,
    OP_NOTE_OFF      = 3'd2,
    OP_TOGGLE_RUN    = 3'd3,
    OP_CLEAR_PATTERN = 3'd4,
    OP_SET_STEP      = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    KIND_STATUS   = 2'd0,
    KIND_NOTE_OFF = 2'd1,
    KIND_NOTE_ON  = 2'd2
  } kind_t;

  // One result item as it waits in the output queue.
  typedef struct packed {
    kind_t      kind;
    logic [3:0] channel;
    logic [6:0] note;
    logic [6:0] velocity;
    logic       last;
    logic [3:0] current_step;
    logic       step_valid;
    logic [6:0] root_note;
  } res_t;

  // Held-note map update request from the core to the root tracker.
  typedef struct packed {
    logic       en;
    logic [6:0] note;
    logic       on;
  } held_upd_t;

  // Index of the highest set bit of an 8-bit group.
  function automatic logic [2:0] enc8(input logic [7:0] v);
    logic [2:0] idx;
    idx = '0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) idx = 3'(i);
    end
    return idx;
  endfunction

  // Index of the highest set bit of a 16-bit group mask.
  function automatic logic [3:0] pri16(input logic [15:0] v);
    logic [3:0] idx;
    idx = '0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) idx = 4'(i);
    end
    return idx;
  endfunction

endpackage

// ===== rtl/mss_root_track.sv =====
// Held-note map and highest-held-note tracker of the step sequencer.
// Depends on mss_pkg for the update struct and the encoder functions.
module mss_root_track (
  input  logic               clk,
  input  logic               rst_n,
  input  mss_pkg::held_upd_t upd,
  output logic [6:0]         root
);
  import mss_pkg::*;

  logic [127:0]      held_r, held_nxt;
  logic [15:0]       grp_any_r, grp_any_nxt;
  logic [15:0][2:0]  grp_top_r, grp_top_nxt;
  logic [3:0]        grp;
  logic [7:0]        byte_old, byte_new;
  logic [3:0]        gsel;

  // Only the group holding the updated note changes; its summary is rebuilt.
  always_comb begin
    grp      = upd.note[6:3];
    byte_old = held_r[{grp, 3'b000} +: 8];
    byte_new = byte_old;
    if (upd.en) byte_new[upd.note[2:0]] = upd.on;

    held_nxt = held_r;
    held_nxt[{grp, 3'b000} +: 8] = byte_new;

    grp_any_nxt      = grp_any_r;
    grp_any_nxt[grp] = |byte_new;
    grp_top_nxt      = grp_top_r;
    grp_top_nxt[grp] = enc8(byte_new);

    // Root reflects the map after this cycle's update.
    gsel = pri16(grp_any_nxt);
    root = (|grp_any_nxt) ? {gsel, grp_top_nxt[gsel]} : NOTE_DEFAULT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r    <= '0;
      grp_any_r <= '0;
    end else begin
      held_r    <= held_nxt;
      grp_any_r <= grp_any_nxt;
    end
  end

  // The per-group top index is only read where its group flag is set.
  always_ff @(posedge clk) begin
    grp_top_r <= grp_top_nxt;
  end

endmodule

// ===== rtl/mss_seq_core.sv =====
// Sequencer core: run state, step phase, pattern and result generation.
// Depends on mss_pkg and on the assertion macros header.
`include "midi_step_sequencer_unit_macros.svh"

module mss_seq_core #(
  parameter int NUM_STEPS = mss_pkg::NUM_STEPS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       acc,
  input  mss_pkg::op_t               op,
  input  logic [6:0]                 note,
  input  logic [6:0]                 velocity,
  input  logic [3:0]                 channel,
  input  logic [3:0]                 step_index,
  input  logic [1:0]                 step_value,
  input  logic [mss_pkg::REG_W-1:0]  per,
  input  logic [mss_pkg::REG_W-1:0]  perm,
  input  logic [mss_pkg::REG_W-1:0]  thr,
  input  logic [6:0]                 root,
  output mss_pkg::held_upd_t         upd,
  output logic [1:0]                 push_n,
  output mss_pkg::res_t              res0,
  output mss_pkg::res_t              res1
);
  import mss_pkg::*;

  localparam int SW = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;

  logic                          run_r, run_nxt;
  logic [PHASE_W-1:0]            phase_r, phase_nxt;
  logic [SW-1:0]                 step_r, step_nxt, step_inc;
  logic                          sounding_r, sounding_nxt;
  logic [6:0]                    snote_r, snote_nxt;
  logic [NUM_STEPS-1:0][1:0]     pattern_r, pattern_nxt;

  logic       note_is_on, reach_thr, fire, stop_note, have_b;
  logic [1:0] st;
  logic [7:0] root8, play8;
  logic [6:0] play_note;
  kind_t      a_kind;
  logic [3:0] a_ch;
  logic [6:0] a_note, a_vel;

  // Next step, its pattern entry and the clamped note it would play.
  always_comb begin
    step_inc = (step_r == SW'(NUM_STEPS - 1)) ? '0 : step_r + SW'(1);
    st       = pattern_r[step_inc];
    root8    = {1'b0, root};
    case (st)
      STEP_UP:   play8 = root8 + OCTAVE;
      STEP_DOWN: play8 = (root8 < OCTAVE) ? 8'd0 : root8 - OCTAVE;
      default:   play8 = root8;
    endcase
    play_note  = (play8 > NOTE_MAX) ? NOTE_MAX[6:0] : play8[6:0];
    note_is_on = (op == OP_NOTE_ON) && (velocity != '0);
    reach_thr  = ({1'b0, thr} <= phase_r);
    fire       = ({1'b0, per} <= phase_r);
    stop_note  = sounding_r && (reach_thr || fire);
  end

  // State update and the up to two events of the accepted item.
  always_comb begin
    run_nxt      = run_r;
    phase_nxt    = phase_r;
    step_nxt     = step_r;
    sounding_nxt = sounding_r;
    snote_nxt    = snote_r;
    pattern_nxt  = pattern_r;
    a_kind       = KIND_STATUS;
    a_ch         = '0;
    a_note       = '0;
    a_vel        = '0;
    have_b       = 1'b0;
    upd          = '0;

    if (acc) begin
      case (op)
        OP_NOTE_ON, OP_NOTE_OFF: begin
          upd.en   = 1'b1;
          upd.note = note;
          upd.on   = note_is_on;
          // Stopped: the note event passes through.
          if (!run_r) begin
            a_kind = note_is_on ? KIND_NOTE_ON : KIND_NOTE_OFF;
            a_ch   = channel;
            a_note = note;
            a_vel  = velocity;
          end
        end
        OP_TOGGLE_RUN: begin
          if (run_r) begin
            if (sounding_r) begin
              a_kind = KIND_NOTE_OFF;
              a_note = snote_r;
            end
            sounding_nxt = 1'b0;
            phase_nxt    = '0;
            step_nxt     = '0;
            run_nxt      = 1'b0;
          end else begin
            run_nxt = 1'b1;
          end
        end
        OP_CLEAR_PATTERN: begin
          pattern_nxt = '0;
        end
        OP_SET_STEP: begin
          if (int'(step_index) < NUM_STEPS) pattern_nxt[SW'(step_index)] = step_value;
        end
        OP_TICK: begin
          if (run_r) begin
            // At most one note off per tick, from the gate or the boundary.
            if (stop_note) begin
              a_kind = KIND_NOTE_OFF;
              a_note = snote_r;
            end
            sounding_nxt = sounding_r && !stop_note;
            if (fire) begin
              step_nxt  = step_inc;
              phase_nxt = phase_r - {1'b0, perm};
              if (st != STEP_OFF) begin
                sounding_nxt = 1'b1;
                snote_nxt    = play_note;
                if (stop_note) begin
                  have_b = 1'b1;
                end else begin
                  a_kind = KIND_NOTE_ON;
                  a_note = play_note;
                  a_vel  = SEQ_VELOCITY;
                end
              end
            end else begin
              phase_nxt = phase_r + PHASE_STEP;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result items: the first event (or a status), then an optional note on.
  always_comb begin
    push_n = acc ? (have_b ? 2'd2 : 2'd1) : 2'd0;

    res0.kind         = a_kind;
    res0.channel      = a_ch;
    res0.note         = a_note;
    res0.velocity     = a_vel;
    res0.last         = !have_b;
    res0.current_step = STEP_OUT_W'(step_nxt);
    res0.step_valid   = run_nxt;
    res0.root_note    = root;

    res1.kind         = KIND_NOTE_ON;
    res1.channel      = '0;
    res1.note         = play_note;
    res1.velocity     = SEQ_VELOCITY;
    res1.last         = 1'b1;
    res1.current_step = STEP_OUT_W'(step_nxt);
    res1.step_valid   = run_nxt;
    res1.root_note    = root;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r      <= 1'b0;
      phase_r    <= '0;
      step_r     <= '0;
      sounding_r <= 1'b0;
      snote_r    <= '0;
      pattern_r  <= '0;
    end else begin
      run_r      <= run_nxt;
      phase_r    <= phase_nxt;
      step_r     <= step_nxt;
      sounding_r <= sounding_nxt;
      snote_r    <= snote_nxt;
      pattern_r  <= pattern_nxt;
    end
  end

  `MSS_ASSERT_IMPL(a_core_stop_silent, !run_r, !sounding_r, "note sounding while stopped")
  `MSS_ASSERT_IMPL(a_core_stop_clear, !run_r, (phase_r == '0) && (step_r == '0),
                   "phase or step not cleared while stopped")
  `MSS_ASSERT(a_core_step_range, step_r <= SW'(NUM_STEPS - 1), "step counter out of range")
  `MSS_ASSERT_IMPL(a_core_two_results, push_n == 2'd2, run_r && (op == OP_TICK) && fire,
                   "two results outside a step boundary")

endmodule

// ===== rtl/mss_out_queue.sv =====
// Result queue of the step sequencer: takes up to two results per cycle,
// hands out one per transfer. Depends on mss_pkg and the assertion macros.
`include "midi_step_sequencer_unit_macros.svh"

module mss_out_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    push_n,
  input  mss_pkg::res_t d0,
  input  mss_pkg::res_t d1,
  output logic          room,
  output logic          out_valid,
  input  logic          out_ready,
  output mss_pkg::res_t out_data
);
  import mss_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = PW + 1;

  res_t            mem [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_b;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            pop;

  // Pointer and fill bookkeeping.
  always_comb begin
    pop        = out_valid && out_ready;
    wr_ptr_b   = wr_ptr_r + PW'(1);
    wr_ptr_nxt = wr_ptr_r + PW'(push_n);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    cnt_nxt    = cnt_r + CW'(push_n) - CW'(pop);
  end

  // Room for the largest burst one item can cause.
  assign room      = (cnt_r <= CW'(QUEUE_DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage: the first result at the write pointer, the second after it.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wr_ptr_r] <= d0;
    if (push_n == 2'd2) mem[wr_ptr_b] <= d1;
  end

  `MSS_ASSERT(a_q_fill_max, cnt_r <= CW'(QUEUE_DEPTH), "result queue overfilled")
  `MSS_ASSERT_IMPL(a_q_push_room, push_n != 2'd0, room, "result pushed without room")
  `MSS_ASSERT(a_q_ptr_fill, (wr_ptr_r - rd_ptr_r) == PW'(cnt_r),
              "queue pointers disagree with fill count")
  `MSS_ASSERT_NEXT(a_q_drain, (cnt_r == CW'(1)) && pop && (push_n == 2'd0), !out_valid,
                   "queue not empty after last entry drained")

endmodule

// ===== rtl/midi_step_sequencer_unit.sv =====
// Top level of the MIDI step sequencer: configuration registers, port
// packing and the core, root tracker and result queue. Depends on mss_pkg.
//
// The block takes one item per clock cycle while in_tready is high: ticks
// (one per audio sample), note on/off, run toggle, pattern clear and step
// writes. Each item is resolved in the cycle it is transferred and yields
// one result, or two when a tick both ends the sounding note and starts the
// next one at a step boundary. Results leave through a four-entry queue at
// one per cycle while out_tready is high, so in_tready drops only while
// more than two results are waiting; a steady stream of single-result items
// runs at full rate. The root note is the highest held note (60 if none),
// taken from a 128-note map summarized in 16 groups of 8. step_period and
// noteoff_threshold are in samples with 8 fraction bits; a period below one
// sample acts as one sample. Write them only while no item is in flight.
module midi_step_sequencer_unit #(
  parameter int NUM_STEPS = mss_pkg::NUM_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input items.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // note[6:0], velocity[13:7], channel[17:14], step_index[21:18], step_value[23:22]
  input  logic [mss_pkg::IN_DATA_W-1:0]   in_tdata,
  // operation[2:0]
  input  logic [mss_pkg::IN_USER_W-1:0]   in_tuser,
  // Result items.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_channel[3:0], out_note[10:4], out_velocity[17:11], current_step[21:18],
  // step_valid[22], root_note[29:23], zero[31:30]
  output logic [mss_pkg::OUT_DATA_W-1:0]  out_tdata,
  // event_kind[1:0]
  output logic [mss_pkg::OUT_USER_W-1:0]  out_tuser,
  output logic                            out_tlast,
  // Configuration writes.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mss_pkg::REG_W-1:0]       cfg_data
);
  import mss_pkg::*;

  logic [REG_W-1:0] per_r, per_nxt, perm_r, perm_nxt, thr_r, thr_nxt;
  logic             cfg_wr, in_acc, room;
  held_upd_t        upd;
  logic [6:0]       root;
  logic [1:0]       push_n;
  res_t             res0, res1, res_out;

  // Configuration: the period is stored clamped, along with period minus one
  // sample, so a step boundary is a single subtract.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    per_nxt  = per_r;
    perm_nxt = perm_r;
    thr_nxt  = thr_r;
    if (cfg_wr) begin
      case (cfg_index)
        REG_STEP_PERIOD: begin
          per_nxt  = (cfg_data < ONE_SAMPLE) ? ONE_SAMPLE : cfg_data;
          perm_nxt = (cfg_data < ONE_SAMPLE) ? '0 : cfg_data - ONE_SAMPLE;
        end
        REG_NOTEOFF_THR: begin
          thr_nxt = cfg_data;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      per_r  <= PERIOD_RST;
      perm_r <= PERIOD_RST - ONE_SAMPLE;
      thr_r  <= THRESH_RST;
    end else begin
      per_r  <= per_nxt;
      perm_r <= perm_nxt;
      thr_r  <= thr_nxt;
    end
  end

  // Input transfer.
  assign in_tready = room;
  assign in_acc    = in_tvalid && in_tready;

  mss_seq_core #(
    .NUM_STEPS (NUM_STEPS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (in_acc),
    .op         (op_t'(in_tuser)),
    .note       (in_tdata[6:0]),
    .velocity   (in_tdata[13:7]),
    .channel    (in_tdata[17:14]),
    .step_index (in_tdata[21:18]),
    .step_value (in_tdata[23:22]),
    .per        (per_r),
    .perm       (perm_r),
    .thr        (thr_r),
    .root       (root),
    .upd        (upd),
    .push_n     (push_n),
    .res0       (res0),
    .res1       (res1)
  );

  mss_root_track u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (upd),
    .root  (root)
  );

  mss_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .d0        (res0),
    .d1        (res1),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res_out)
  );

  // Output packing.
  assign out_tdata = {2'b00, res_out.root_note, res_out.step_valid, res_out.current_step,
                      res_out.velocity, res_out.note, res_out.channel};
  assign out_tuser = res_out.kind;
  assign out_tlast = res_out.last;

endmodule
